[rtl/radix_digit_converter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the radix digit converter
// Clocked checks that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// A property that must hold at every rising clock edge outside reset.
`define RDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define RDC_NEVER(lbl, cond, msg) \
   `RDC_ASSERT(lbl, !(cond), msg)

`endif

[rtl/rdc_pkg.sv]
// ----------------------------------------------------------------------------
// Radix digit converter package
// Sizes and the job record shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

   // Width of the value to convert and depth of the digit buffer.
   localparam int VALUE_WIDTH = 31;
   localparam int MAX_DIGITS  = 31;
   localparam int BASE_WIDTH  = 8;

   // Derived widths.
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int BIT_W = $clog2(VALUE_WIDTH);

   // Depth of the job queue between front and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One conversion job.
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [BASE_WIDTH-1:0]  base;
   } job_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

[rtl/rdc_front.sv]
// ----------------------------------------------------------------------------
// Radix digit converter front end
// Takes command transfers and drops jobs that produce no digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdc_front
   import rdc_pkg::*;
(
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire logic [BASE_WIDTH-1:0]  req_base,
   input  wire queue_status_type       q_status,
   output logic                        push,
   output job_type                     push_job
);

   logic accept;
   logic has_digits;

   // A command is taken whenever the queue has room.
   assign busy   = q_status.full;
   assign accept = start && !busy;

   // Zero values and bases below two yield no digits and are not queued.
   assign has_digits = (req_base >= BASE_WIDTH'(2)) && (req_value != '0);

   assign push           = accept && has_digits;
   assign push_job.value = req_value;
   assign push_job.base  = req_base;

endmodule

`default_nettype wire

[rtl/rdc_queue.sv]
// ----------------------------------------------------------------------------
// Radix digit converter job queue
// Short first-in first-out buffer between the front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdc_queue
   import rdc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire job_type     push_job,
   input  wire logic        pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;
   logic              do_push, do_pop;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_job       = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/rdc_back.sv]
// ----------------------------------------------------------------------------
// Radix digit converter back end
// Bit-serial divider that fills the digit buffer, then plays it out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "radix_digit_converter_assert.svh"

module rdc_back
   import rdc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire job_type               head_job,
   input  wire queue_status_type      q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   output logic [BASE_WIDTH-1:0]      rsp_digit,
   output logic                       rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]             state_ff,    state_in;
   logic [VALUE_WIDTH-1:0] quot_ff,     quot_in;
   logic [BASE_WIDTH-1:0]  rem_ff,      rem_in;
   logic [BASE_WIDTH-1:0]  base_ff,     base_in;
   logic [BIT_W-1:0]       bit_cnt_ff,  bit_cnt_in;
   logic [CNT_W-1:0]       count_ff,    count_in;
   logic [IDX_W-1:0]       emit_idx_ff, emit_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BASE_WIDTH-1:0]  rsp_digit_ff;
   logic                   rsp_last_ff,  rsp_last_in;
   logic [BASE_WIDTH-1:0]  digit_buf_ff [MAX_DIGITS];

   logic [BASE_WIDTH:0]    rem_shift;
   logic [BASE_WIDTH:0]    rem_diff;
   logic                   q_bit;
   logic [BASE_WIDTH-1:0]  rem_step;
   logic [VALUE_WIDTH-1:0] quot_step;
   logic                   last_bit;
   logic                   buf_we;

   // One restoring division step: shift in the next dividend bit.
   assign rem_shift = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, base_ff};
   assign q_bit     = (rem_shift >= {1'b0, base_ff});
   assign rem_step  = q_bit ? rem_diff[BASE_WIDTH-1:0] : rem_shift[BASE_WIDTH-1:0];
   assign quot_step = {quot_ff[VALUE_WIDTH-2:0], q_bit};
   assign last_bit  = (bit_cnt_ff == BIT_W'(VALUE_WIDTH - 1));

   assign pop    = (state_ff == ST_IDLE) && !q_status.empty;
   assign buf_we = (state_ff == ST_DIV) && last_bit;

   // Sequencer: load a job, divide digit by digit, then emit.
   always_comb begin
      state_in     = state_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      bit_cnt_in   = bit_cnt_ff;
      count_in     = count_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               quot_in    = head_job.value;
               base_in    = head_job.base;
               rem_in     = '0;
               bit_cnt_in = '0;
               count_in   = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (last_bit) begin
               count_in = count_ff + 1'b1;
               if ((quot_step == '0) || (count_ff == CNT_W'(MAX_DIGITS - 1))) begin
                  emit_idx_in = count_ff[IDX_W-1:0];
                  state_in    = ST_EMIT;
               end else begin
                  quot_in    = quot_step;
                  rem_in     = '0;
                  bit_cnt_in = '0;
               end
            end else begin
               quot_in    = quot_step;
               rem_in     = rem_step;
               bit_cnt_in = bit_cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = (emit_idx_ff == '0);
            if (emit_idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               emit_idx_in = emit_idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         quot_ff      <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         quot_ff      <= quot_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      emit_idx_ff  <= emit_idx_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Digit buffer, least significant digit at index zero. During playout
   // the addressed digit is read straight into the digit output register.
   always_ff @(posedge clock) begin
      if (buf_we) begin
         digit_buf_ff[count_ff[IDX_W-1:0]] <= rem_step;
      end
      if (state_ff == ST_EMIT) begin
         rsp_digit_ff <= digit_buf_ff[emit_idx_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_digit = rsp_digit_ff;
   assign rsp_last  = rsp_last_ff;

   // The digits of one run leave in consecutive cycles.
   `RDC_ASSERT(a_run_contiguous, rsp_valid_ff && !rsp_last_ff |=> rsp_valid_ff, "gap in digit run")
   // The final digit is followed by a quiet cycle.
   `RDC_ASSERT(a_gap_after_last, rsp_valid_ff && rsp_last_ff |=> !rsp_valid_ff, "no gap after run")
   // Every emitted digit lies below the base of its run.
   `RDC_ASSERT(a_digit_range, rsp_valid_ff |-> rsp_digit_ff < base_ff, "digit not below base")
   // The partial remainder stays below the base during division.
   `RDC_NEVER(a_rem_range, (state_ff == ST_DIV) && (rem_ff >= base_ff), "remainder overflow")

endmodule

`default_nettype wire

[rtl/radix_digit_converter.sv]
// ----------------------------------------------------------------------------
// Radix digit converter
// Writes a non-negative integer in a base from 2 to 255, one digit a result.
// ----------------------------------------------------------------------------
// A command transfer happens on a rising edge with start high and busy low.
// Values of zero and bases below two are taken and produce no digits. Every
// other job goes into a two-entry queue; busy is high only while it is full.
// The back end divides with a one-bit-per-cycle restoring divider. It
// loads a job from the queue, computes its digits one after another, then
// emits them, and takes the next job only once it is idle again; a job
// has at most 31 digits (MAX_DIGITS). Digits leave most significant first on
// consecutive cycles, each marked by rsp_valid for one cycle, the final one
// with rsp_last; the receiver cannot hold them off and must take each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_converter
   import rdc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire logic [BASE_WIDTH-1:0]  req_base,
   output logic                        rsp_valid,
   output logic [BASE_WIDTH-1:0]       rsp_digit,
   output logic                        rsp_last
);

   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             push;
   logic             pop;

   // Command intake and classification.
   rdc_front u_front (
      .start    (start),
      .busy     (busy),
      .req_value(req_value),
      .req_base (req_base),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // Job queue between the two halves.
   rdc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head_job(head_job),
      .q_status(q_status)
   );

   // Division and digit playout.
   rdc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_digit(rsp_digit),
      .rsp_last (rsp_last)
   );

endmodule

`default_nettype wire
